[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge, reset included
`define BMRSC_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("bmrsc check failed");

// checked outside reset only
`define BMRSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bmrsc check failed");

`endif

[rtl/core/bmrsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bmrsc_pkg;

   localparam int MAP_BITS_DEF   = 1024;
   localparam int WORD_WIDTH_DEF = 32;

   localparam int START_W  = 10;
   localparam int COUNT_W  = 11;
   localparam int RESULT_W = 32;
   // start + count never exceeds 3070, so bit positions fit here
   localparam int POS_W    = 12;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_INIT  = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [START_W-1:0]   start_index;
      logic [COUNT_W-1:0]   bit_count;
      logic                 fill_value;
   } req_type;

   typedef struct packed {
      logic [RESULT_W-1:0]  word_value;
      logic [COUNT_W-1:0]   object_count;
   } rsp_type;

   // classified command handed from front to back
   typedef struct packed {
      op_type               op;
      logic [POS_W-1:0]     lo;
      logic [POS_W-1:0]     hi;
      logic                 fill;
      logic                 rd_ok;
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/bmrsc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmrsc_front import bmrsc_pkg::*; #(
   parameter int MAP_BITS = MAP_BITS_DEF
) (
   input  wire logic    start,
   input  wire req_type req_item,
   input  wire logic    q_full,
   input  wire logic    clearing,
   output logic         busy,
   output logic         push,
   output cmd_type      cmd
);

   localparam int MB_W  = $clog2(MAP_BITS + 1);
   localparam int CMP_W = (MB_W > POS_W) ? MB_W : POS_W;

   logic [POS_W-1:0] end_sum;
   logic [POS_W-1:0] start_pos;
   logic [POS_W-1:0] hi_clip;
   logic             in_map;

   assign busy = clearing || q_full;
   assign push = start && !busy;

   always_comb begin
      start_pos = POS_W'(req_item.start_index);
      end_sum   = start_pos + POS_W'(req_item.bit_count);
      in_map    = CMP_W'(req_item.start_index) < CMP_W'(MAP_BITS);
      // clip the range at the map end
      if (CMP_W'(end_sum) > CMP_W'(MAP_BITS)) begin
         hi_clip = POS_W'(MAP_BITS);
      end else begin
         hi_clip = end_sum;
      end

      cmd.op    = req_item.op;
      cmd.fill  = req_item.fill_value;
      cmd.rd_ok = 1'b0;
      unique case (req_item.op)
         OP_SET, OP_CLEAR: begin
            cmd.lo = start_pos;
            cmd.hi = in_map ? hi_clip : start_pos;
         end
         OP_INIT: begin
            cmd.lo = '0;
            cmd.hi = POS_W'(req_item.bit_count);
         end
         OP_READ: begin
            cmd.lo    = start_pos;
            cmd.hi    = start_pos;
            cmd.rd_ok = in_map;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/bmrsc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmrsc_queue import bmrsc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output cmd_type      pop_data,
   output logic         empty,
   output logic         full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/bmrsc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module bmrsc_back import bmrsc_pkg::*; #(
   parameter int MAP_BITS   = MAP_BITS_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire cmd_type q_data,
   output logic         pop,
   output logic         clearing,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   localparam int NWORDS = (MAP_BITS + WORD_WIDTH - 1) / WORD_WIDTH;
   localparam int IW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
   localparam int BW     = $clog2(NWORDS * WORD_WIDTH + 1);
   localparam int CW     = (BW > POS_W) ? BW : POS_W;
   localparam int OW     = $clog2(WORD_WIDTH + 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_DRAIN
   } state_type;

   state_type               state_ff;
   cmd_type                 cmd_ff;
   logic [IW-1:0]           r_idx_ff;
   logic [CW-1:0]           r_base_ff;
   logic                    m_valid_ff;
   logic [IW-1:0]           m_idx_ff;
   logic [CW-1:0]           m_base_ff;
   logic                    m_last_ff;
   logic [COUNT_W-1:0]      objects_ff;
   logic [WORD_WIDTH-1:0]   rd_data_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_item_ff;

   logic [WORD_WIDTH-1:0]   mem [NWORDS];

   logic [CW-1:0]           lo_c;
   logic [CW-1:0]           hi_c;
   logic [CW-1:0]           r_top;
   logic                    idx_end;
   logic                    found;
   logic                    issue_last;
   logic [CW-1:0]           m_top;
   logic                    in_win;
   logic [OW-1:0]           a_off;
   logic [OW-1:0]           b_off;
   logic [WORD_WIDTH-1:0]   mask;
   logic                    upd_we;
   logic [WORD_WIDTH-1:0]   upd_data;
   logic                    mem_we;
   logic [IW-1:0]           mem_waddr;
   logic [WORD_WIDTH-1:0]   mem_wdata;

   assign pop        = (state_ff == S_IDLE) && !q_empty;
   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // issue side: decide whether the word being read is the last one
   always_comb begin
      lo_c    = CW'(cmd_ff.lo);
      hi_c    = CW'(cmd_ff.hi);
      r_top   = r_base_ff + CW'(WORD_WIDTH);
      idx_end = (r_idx_ff == IW'(NWORDS - 1));
      unique case (cmd_ff.op)
         OP_READ:                   found = lo_c < r_top;
         OP_SET, OP_CLEAR, OP_INIT: found = r_top >= hi_c;
      endcase
      issue_last = idx_end || found;
   end

   // update side: mask of range bits inside the word just read
   always_comb begin
      m_top  = m_base_ff + CW'(WORD_WIDTH);
      in_win = (lo_c < m_top) && (hi_c > m_base_ff);
      a_off  = (lo_c > m_base_ff) ? OW'(lo_c - m_base_ff) : '0;
      b_off  = (hi_c < m_top) ? OW'(hi_c - m_base_ff) : OW'(WORD_WIDTH);
      if (in_win) begin
         mask = ~({WORD_WIDTH{1'b1}} << b_off) & ({WORD_WIDTH{1'b1}} << a_off);
      end else begin
         mask = '0;
      end

      unique case (cmd_ff.op)
         OP_SET: begin
            upd_we   = m_valid_ff && in_win;
            upd_data = rd_data_ff | mask;
         end
         OP_CLEAR: begin
            upd_we   = m_valid_ff && in_win;
            upd_data = rd_data_ff & ~mask;
         end
         OP_INIT: begin
            // whole words while the word starts below the object count
            upd_we   = m_valid_ff && (m_base_ff < hi_c);
            upd_data = {WORD_WIDTH{cmd_ff.fill}};
         end
         OP_READ: begin
            upd_we   = 1'b0;
            upd_data = rd_data_ff;
         end
      endcase

      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = r_idx_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = upd_we;
         mem_waddr = m_idx_ff;
         mem_wdata = upd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[r_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cmd_ff        <= '0;
         r_idx_ff      <= '0;
         m_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         objects_ff    <= '0;
      end else begin
         m_valid_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;

         unique case (state_ff)
            S_CLEAR: begin
               if (idx_end) begin
                  state_ff <= S_IDLE;
               end else begin
                  r_idx_ff <= r_idx_ff + IW'(1);
               end
            end
            S_IDLE: begin
               if (!q_empty) begin
                  cmd_ff    <= q_data;
                  r_idx_ff  <= '0;
                  r_base_ff <= '0;
                  if (q_data.op == OP_INIT) begin
                     objects_ff <= q_data.hi[COUNT_W-1:0];
                  end
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               m_valid_ff <= 1'b1;
               m_idx_ff   <= r_idx_ff;
               m_base_ff  <= r_base_ff;
               m_last_ff  <= issue_last;
               if (issue_last) begin
                  state_ff <= S_DRAIN;
               end else begin
                  r_idx_ff  <= r_idx_ff + IW'(1);
                  r_base_ff <= r_top;
               end
            end
            S_DRAIN: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (m_valid_ff && m_last_ff) begin
            rsp_strobe_ff            <= 1'b1;
            rsp_item_ff.object_count <= objects_ff;
            if (cmd_ff.op == OP_READ && cmd_ff.rd_ok) begin
               rsp_item_ff.word_value <= RESULT_W'(rd_data_ff);
            end else begin
               rsp_item_ff.word_value <= '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/bitmap_range_set_clear_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel   ports                          direction  handshake
// request   start, busy, req_item          in         taken when start && !busy
// response  rsp_strobe, rsp_item           out        one cycle, cannot be held off
//
// an item's walk reads n = 1 .. NWORDS store words, one store word a cycle, passing
// through S_IDLE, S_WALK and S_DRAIN of the word walker
// the request side queues up to two items while the walker is busy
// after reset the store is cleared one word a cycle, busy held high meanwhile
// the result is registered through m_last_ff and then rsp_strobe_ff after the walker's last word read

module bitmap_range_set_clear_core import bmrsc_pkg::*; #(
   parameter int MAP_BITS   = MAP_BITS_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type pop_cmd;
   logic    q_empty;
   logic    q_full;
   logic    clearing;

   bmrsc_front #(
      .MAP_BITS (MAP_BITS)
   ) u_front (
      .start    (start),
      .req_item (req_item),
      .q_full   (q_full),
      .clearing (clearing),
      .busy     (busy),
      .push     (push),
      .cmd      (push_cmd)
   );

   bmrsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty),
      .full      (q_full)
   );

   bmrsc_back #(
      .MAP_BITS   (MAP_BITS),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (pop_cmd),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

[rtl/core/bmrsc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bmrsc_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe
);

   // store clearing pass keeps requests off right after reset
   `BMRSC_ASSERT_ALWAYS(a_busy_after_reset, clock, reset |=> busy)
   `BMRSC_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_strobe)
   // every item passes through S_IDLE, S_WALK and S_DRAIN, so responses never come back to back
   `BMRSC_ASSERT(a_rsp_spaced, clock, reset, rsp_strobe |=> !rsp_strobe)
   // no response strobe shows up as the design leaves reset
   `BMRSC_ASSERT(a_no_rsp_early, clock, reset, $past(reset) |-> !rsp_strobe)
   // with an item accepted some result strobe must follow within the checked window
   `BMRSC_ASSERT(a_rsp_follows, clock, reset, (start && !busy) |-> ##[1:64] rsp_strobe)

endmodule

bind bitmap_range_set_clear_core bmrsc_checker u_bmrsc_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
   import bmrsc_pkg::*;

   localparam int MAP_BITS   = MAP_BITS_DEF;
   localparam int WORD_WIDTH = WORD_WIDTH_DEF;
   localparam int NWORDS     = (MAP_BITS + WORD_WIDTH - 1) / WORD_WIDTH;
   localparam int RANDOM_ITEMS = 1900;
   localparam int CALM_ITEMS   = 300;
   localparam int DRAIN_CYCLES = 2 * (NWORDS + 4);
   localparam int CYCLE_LIMIT  = 600000;

   // shadow copy of the allocation bitmap, predicts one response per request
   class bitmap_mirror;
      logic [WORD_WIDTH-1:0] map_q [NWORDS];
      logic [COUNT_W-1:0]    objects_q;
      rsp_type               expected_rsp [$];
      int                    errors;
      int                    checked;
      int                    op_seen [4];

      function new();
         for (int w = 0; w < NWORDS; w++) map_q[w] = '0;
         objects_q = '0;
         errors = 0;
         checked = 0;
         for (int k = 0; k < 4; k++) op_seen[k] = 0;
      endfunction

      function void note_request(req_type r);
         int lo;
         int hi;
         int nw;
         rsp_type p;
         lo = int'(r.start_index);
         p.word_value = '0;
         op_seen[int'(r.op)]++;
         case (r.op)
            OP_SET, OP_CLEAR: begin
               if (lo < MAP_BITS) begin
                  hi = lo + int'(r.bit_count);
                  if (hi > MAP_BITS) hi = MAP_BITS;
                  for (int b = lo; b < hi; b++)
                     map_q[b / WORD_WIDTH][b % WORD_WIDTH] = (r.op == OP_SET);
               end
            end
            OP_INIT: begin
               nw = (int'(r.bit_count) + WORD_WIDTH - 1) / WORD_WIDTH;
               if (nw > NWORDS) nw = NWORDS;
               objects_q = r.bit_count;
               for (int w = 0; w < nw; w++)
                  map_q[w] = r.fill_value ? '1 : '0;
            end
            default: begin
               if (lo < MAP_BITS) p.word_value = map_q[lo / WORD_WIDTH];
            end
         endcase
         p.object_count = objects_q;
         expected_rsp.push_back(p);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected response word_value=%h object_count=%0d",
                     $time, a.word_value, a.object_count);
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            checked++;
            if (a.word_value !== e.word_value) begin
               $display("%0t: word_value mismatch expected %h actual %h",
                        $time, e.word_value, a.word_value);
               errors++;
            end
            if (a.object_count !== e.object_count) begin
               $display("%0t: object_count mismatch expected %0d actual %0d",
                        $time, e.object_count, a.object_count);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   bitmap_mirror mirror;
   int cycles = 0;

   bitmap_range_set_clear_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) mirror.note_request(req_item);
         if (rsp_strobe) mirror.check_response(rsp_item);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, mirror.pending());
         $display("** bitmap_range_set_clear_core: FAILED **");
         $finish;
      end
   end

   function automatic req_type make_item(op_type op, int first, int count, bit fill);
      req_type r;
      r.op          = op;
      r.start_index = first[START_W-1:0];
      r.bit_count   = count[COUNT_W-1:0];
      r.fill_value  = fill;
      return r;
   endfunction

   function automatic int random_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return $urandom_range(0, 40);
      else if (pick < 85) return $urandom_range(0, MAP_BITS);
      else if (pick < 92) return $urandom_range(MAP_BITS + 1, 2 ** COUNT_W - 1);
      else return WORD_WIDTH * $urandom_range(0, NWORDS);
   endfunction

   function automatic req_type random_item();
      req_type r;
      int pick;
      int first;
      pick = $urandom_range(0, 99);
      first = $urandom_range(0, 2 ** START_W - 1);
      // word-aligned ranges now and then so whole-word paths get hit
      if ($urandom_range(0, 9) == 0) first = WORD_WIDTH * $urandom_range(0, NWORDS - 1);
      r = make_item(OP_READ, first, random_count(), $urandom_range(0, 1));
      if (pick < 30) r.op = OP_SET;
      else if (pick < 60) r.op = OP_CLEAR;
      else if (pick < 66) r.op = OP_INIT;
      return r;
   endfunction

   task automatic send_item(input req_type r);
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start    <= 1'b0;
      req_item <= req_type'({$urandom, $urandom});
      repeat (n) @(negedge clock);
   endtask

   initial begin
      req_type directed [$];
      mirror = new();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // store must read back cleared after reset
      directed.push_back(make_item(OP_READ, 0, 0, 0));
      directed.push_back(make_item(OP_READ, 1023, 2047, 1));
      directed.push_back(make_item(OP_INIT, 0, MAP_BITS, 1));
      directed.push_back(make_item(OP_READ, 0, 0, 0));
      directed.push_back(make_item(OP_CLEAR, 5, 3, 1));
      directed.push_back(make_item(OP_CLEAR, 30, 70, 0));
      directed.push_back(make_item(OP_CLEAR, 200, 0, 0));
      // clipped at the map end
      directed.push_back(make_item(OP_CLEAR, 1000, 100, 0));
      directed.push_back(make_item(OP_READ, 0, 0, 0));
      directed.push_back(make_item(OP_READ, 64, 0, 0));
      directed.push_back(make_item(OP_READ, 1023, 0, 0));
      directed.push_back(make_item(OP_SET, 1023, 2047, 0));
      directed.push_back(make_item(OP_SET, 64, 32, 0));
      directed.push_back(make_item(OP_READ, 999, 0, 0));
      // init with partial last word fills the whole word
      directed.push_back(make_item(OP_INIT, 512, 33, 0));
      directed.push_back(make_item(OP_READ, 33, 0, 0));
      directed.push_back(make_item(OP_READ, 64, 0, 0));
      directed.push_back(make_item(OP_INIT, 0, 0, 1));
      directed.push_back(make_item(OP_INIT, 0, 2047, 1));
      directed.push_back(make_item(OP_CLEAR, 0, MAP_BITS, 0));
      directed.push_back(make_item(OP_READ, 512, 0, 0));
      directed.push_back(make_item(OP_SET, 0, MAP_BITS, 0));
      directed.push_back(make_item(OP_CLEAR, 31, 2, 0));
      directed.push_back(make_item(OP_READ, 32, 0, 1));
      directed.push_back(make_item(OP_INIT, 0, 1, 0));

      @(negedge clock);
      foreach (directed[k]) send_item(directed[k]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_item(random_item());
         if (n < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 16));
      end
      start <= 1'b0;

      while (mirror.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d set, %0d clear, %0d init and %0d read requests",
               mirror.op_seen[OP_SET], mirror.op_seen[OP_CLEAR],
               mirror.op_seen[OP_INIT], mirror.op_seen[OP_READ]);
      $display("%0d responses compared, %0d errors in %0d cycles",
               mirror.checked, mirror.errors, cycles);
      if (mirror.errors == 0 && mirror.pending() == 0) begin
         $display("** bitmap_range_set_clear_core: PASSED **");
      end else begin
         $display("** bitmap_range_set_clear_core: FAILED **");
      end
      $finish;
   end

endmodule

[bitmap_range_set_clear_core.f]
+incdir+rtl/core
rtl/core/bmrsc_pkg.sv
rtl/core/bmrsc_front.sv
rtl/core/bmrsc_queue.sv
rtl/core/bmrsc_back.sv
rtl/core/bitmap_range_set_clear_core.sv
rtl/core/bmrsc_checker.sv
verif/tb.sv
